/* src/rhtt_pkg.sv */
// ----------------------------------------------------------------------------
// rhtt_pkg
// shared types and constants for the rectangle hit-test table
// ----------------------------------------------------------------------------
`default_nettype none

package rhtt_pkg;

    localparam int MAX_BUTTONS_DEF = 16;
    localparam int COORD_W         = 10;
    localparam int EDGE_W          = 11;
    localparam int INDEX_W         = 4;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic [EDGE_W-1:0] left_edge;
        logic [EDGE_W-1:0] top_edge;
        logic [EDGE_W-1:0] right_edge;
        logic [EDGE_W-1:0] bottom_edge;
    } box_t;

    localparam int BOX_W = $bits(box_t);

endpackage

`default_nettype wire

/* src/rhtt_ram.sv */
// ----------------------------------------------------------------------------
// rhtt_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module rhtt_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* src/rectangle_hit_test_table_core.sv */
// ----------------------------------------------------------------------------
// rectangle_hit_test_table_core
// table of button boxes; a write item stores one box, a query item scans the
// table for the lowest active box that holds the point
// ----------------------------------------------------------------------------
// write item: result strobed on done in the cycle after accept, busy stays low
// query item: result on done once the scan over the box ram hits or reaches the
//   last entry; it reads one entry per cycle and compares behind its registered read
// busy is high during a scan; results cannot be stalled
// reset clears state and the active flags; box ram needs no clearing pass
`default_nettype none

module rectangle_hit_test_table_core #(
    parameter int MAX_BUTTONS = rhtt_pkg::MAX_BUTTONS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        mode,
    input  wire logic [rhtt_pkg::INDEX_W-1:0] entry_index,
    input  wire logic [rhtt_pkg::COORD_W-1:0] center_x,
    input  wire logic [rhtt_pkg::COORD_W-1:0] center_y,
    input  wire logic [rhtt_pkg::COORD_W-1:0] box_width,
    input  wire logic [rhtt_pkg::COORD_W-1:0] box_height,
    input  wire logic                        enable,
    input  wire logic [rhtt_pkg::COORD_W-1:0] point_x,
    input  wire logic [rhtt_pkg::COORD_W-1:0] point_y,
    output logic                             done,
    output logic                             hit,
    output logic      [rhtt_pkg::INDEX_W-1:0] button_index,
    output logic                             entry_error
);

    localparam int ADDR_W = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
    localparam int CNT_W  = $clog2(MAX_BUTTONS + 1);
    localparam int SLOT_W = 9;

    rhtt_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [ADDR_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [MAX_BUTTONS-1:0] active_reg, active_next;
    logic [rhtt_pkg::COORD_W-1:0] px_reg, px_next;
    logic [rhtt_pkg::COORD_W-1:0] py_reg, py_next;

    logic                          done_reg, done_next;
    logic                          hit_reg, hit_next;
    logic [rhtt_pkg::INDEX_W-1:0]  index_reg, index_next;
    logic                          error_reg, error_next;

    logic accept;
    logic write_item;
    logic query_item;
    logic [rhtt_pkg::COORD_W-1:0] half_w;
    logic [rhtt_pkg::COORD_W-1:0] half_h;
    logic corner_neg;
    logic slot_ok;
    logic [SLOT_W-1:0] slot_wide;
    logic [ADDR_W-1:0] wr_addr;
    rhtt_pkg::box_t    wr_box;
    logic              wr_en;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    rhtt_pkg::box_t    rd_box;

    logic [rhtt_pkg::EDGE_W-1:0] px_ext;
    logic [rhtt_pkg::EDGE_W-1:0] py_ext;
    logic in_box;
    logic match;
    logic last_entry;
    logic finish;

    assign accept     = start && (state_reg == rhtt_pkg::ST_IDLE);
    assign write_item = accept && (mode == rhtt_pkg::MODE_WRITE);
    assign query_item = accept && (mode == rhtt_pkg::MODE_QUERY);

    // write path: corners from center and half size
    assign half_w     = box_width >> 1;
    assign half_h     = box_height >> 1;
    assign corner_neg = (center_x < half_w) || (center_y < half_h);
    assign slot_wide  = SLOT_W'(entry_index);
    assign slot_ok    = slot_wide < SLOT_W'(MAX_BUTTONS);
    assign wr_addr    = slot_wide[ADDR_W-1:0];
    assign wr_en      = write_item && !corner_neg && slot_ok;

    assign wr_box.left_edge   = rhtt_pkg::EDGE_W'(center_x) - rhtt_pkg::EDGE_W'(half_w);
    assign wr_box.top_edge    = rhtt_pkg::EDGE_W'(center_y) - rhtt_pkg::EDGE_W'(half_h);
    assign wr_box.right_edge  = rhtt_pkg::EDGE_W'(center_x) + rhtt_pkg::EDGE_W'(half_w);
    assign wr_box.bottom_edge = rhtt_pkg::EDGE_W'(center_y) + rhtt_pkg::EDGE_W'(half_h);

    // scan path: read one entry per cycle, compare it in the cycle after its read
    assign rd_en   = (state_reg == rhtt_pkg::ST_SCAN) && (scan_cnt_reg < CNT_W'(MAX_BUTTONS));
    assign rd_addr = scan_cnt_reg[ADDR_W-1:0];

    rhtt_ram #(
        .WIDTH  (rhtt_pkg::BOX_W),
        .DEPTH  (MAX_BUTTONS),
        .ADDR_W (ADDR_W)
    ) u_box_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_box),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_box)
    );

    assign px_ext = rhtt_pkg::EDGE_W'(px_reg);
    assign py_ext = rhtt_pkg::EDGE_W'(py_reg);
    assign in_box = (px_ext >= rd_box.left_edge) && (px_ext <= rd_box.right_edge) &&
                    (py_ext >= rd_box.top_edge) && (py_ext <= rd_box.bottom_edge);
    assign match      = cmp_valid_reg && active_reg[cmp_idx_reg] && in_box;
    assign last_entry = cmp_idx_reg == ADDR_W'(MAX_BUTTONS - 1);
    assign finish     = cmp_valid_reg && (match || last_entry);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rhtt_pkg::ST_IDLE:
            begin
                if (query_item)
                begin
                    state_next = rhtt_pkg::ST_SCAN;
                end
            end
            rhtt_pkg::ST_SCAN:
            begin
                if (finish)
                begin
                    state_next = rhtt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rhtt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        scan_cnt_next  = scan_cnt_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        active_next    = active_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        done_next      = 1'b0;
        hit_next       = hit_reg;
        index_next     = index_reg;
        error_next     = error_reg;
        case (state_reg)
            rhtt_pkg::ST_IDLE:
            begin
                if (write_item)
                begin
                    if (wr_en)
                    begin
                        active_next[wr_addr] = enable;
                    end
                    done_next  = 1'b1;
                    hit_next   = 1'b0;
                    index_next = entry_index;
                    error_next = corner_neg;
                end
                if (query_item)
                begin
                    scan_cnt_next = '0;
                    px_next       = point_x;
                    py_next       = point_y;
                end
            end
            rhtt_pkg::ST_SCAN:
            begin
                if (rd_en)
                begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                cmp_valid_next = rd_en && !finish;
                cmp_idx_next   = rd_addr;
                if (finish)
                begin
                    done_next  = 1'b1;
                    hit_next   = match;
                    index_next = match ? rhtt_pkg::INDEX_W'(cmp_idx_reg) : '0;
                    error_next = 1'b0;
                end
            end
            default:
            begin
                cmp_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rhtt_pkg::ST_IDLE;
            scan_cnt_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            active_reg    <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            cmp_valid_reg <= cmp_valid_next;
            active_reg    <= active_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        hit_reg     <= hit_next;
        index_reg   <= index_next;
        error_reg   <= error_next;
    end

    assign busy         = state_reg != rhtt_pkg::ST_IDLE;
    assign done         = done_reg;
    assign hit          = hit_reg;
    assign button_index = index_reg;
    assign entry_error  = error_reg;

    a_hit_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(hit_reg && error_reg))
        else $error("hit and entry error together");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_cnt_reg <= CNT_W'(MAX_BUTTONS))
        else $error("scan counter past table");

    a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> state_reg == rhtt_pkg::ST_SCAN)
        else $error("compare outside scan");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        query_item |=> busy && !done_reg)
        else $error("query did not start a scan");

endmodule

`default_nettype wire
